@@ hdl/assert_macros.svh @@
// Assertion macros for the lock table RTL (used by ltm_back).
// Needs a clock i_clk and an active-low reset i_rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond holds in the same cycle as trig.
`define LTM_ASSERT_IMP(lbl, trig, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error("assertion failed");

// Check that cond holds in the cycle after trig.
`define LTM_ASSERT_NXT(lbl, trig, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error("assertion failed");

`endif

@@ hdl/ltm_pkg.sv @@
// Shared types and codes of the lock table manager.
// No dependencies.
package ltm_pkg;

    localparam logic [1:0] CMD_STAT = 2'd0;
    localparam logic [1:0] CMD_ACQ  = 2'd1;
    localparam logic [1:0] CMD_REL  = 2'd2;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_NOENT  = 3'd1;
    localparam logic [2:0] ST_QUEUED = 3'd2;
    localparam logic [2:0] ST_FULL   = 3'd3;
    localparam logic [2:0] ST_QFULL  = 3'd4;

    localparam logic [31:0] GRANT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_STAT,
        OP_ACQ,
        OP_REL
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [15:0] client;
        logic [63:0] key;
    } t_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MREAD,
        S_EXEC,
        S_WDATA,
        S_SECOND
    } t_state;

endpackage

@@ hdl/lock_table_manager.sv @@
// Top level of the lock table manager.
// Depends on ltm_pkg, ltm_front, ltm_back (and ltm_ram below it).
//
// Each request is searched for in the table one entry per cycle through the
// key store's read port, and the search stops at the first match. The
// entry's record is then read and the request is applied to it. A release
// that hands the lock to a waiter gives its own result first and the
// waiter's result after it. The back end takes the next item from the buffer
// once it is idle again; a stalled result holds the back end until it is
// taken. A two-item input buffer accepts new requests while one is being
// worked on, and stalls the input once both places are taken. The output
// register lets a result wait while the next item is read in.
// Reset clears the entry valid and held flags at once; no clearing pass runs.
module lock_table_manager #(
    parameter int ENTRIES    = 64,
    parameter int WAIT_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_client,
    input  logic [63:0] i_lock_id,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [15:0] o_client_out,
    output logic [63:0] o_lock_out,
    output logic [31:0] o_grant_count,
    output logic        o_last
);
    import ltm_pkg::*;

    logic  qvalid, pop;
    t_item qitem;

    // accept and classify
    ltm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_command(i_command), .i_client(i_client), .i_lock_id(i_lock_id),
        .o_qvalid(qvalid), .o_qitem(qitem), .i_pop(pop)
    );

    // search and execute
    ltm_back #(.ENTRIES(ENTRIES), .WAIT_DEPTH(WAIT_DEPTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_qvalid(qvalid), .i_qitem(qitem),
        .o_pop(pop), .o_valid(o_valid), .i_stall(i_stall), .o_status(o_status),
        .o_client_out(o_client_out), .o_lock_out(o_lock_out),
        .o_grant_count(o_grant_count), .o_last(o_last)
    );
endmodule

@@ hdl/ltm_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ltm_ram #(
    parameter int W = 8,
    parameter int D = 2
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hdl/ltm_front.sv @@
// Front end of the lock table: accepts items, decodes the command and
// queues them in a two-entry buffer. Depends on ltm_pkg.
module ltm_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [1:0]    i_command,
    input  logic [15:0]   i_client,
    input  logic [63:0]   i_lock_id,
    output logic          o_qvalid,
    output ltm_pkg::t_item o_qitem,
    input  logic          i_pop
);
    import ltm_pkg::*;

    t_item       r_buf [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    t_item       dec;
    logic        push;

    // classify the command; an unused code behaves as stat
    always_comb begin
        dec.client = i_client;
        dec.key    = i_lock_id;
        unique case (i_command)
            CMD_ACQ: dec.op = OP_ACQ;
            CMD_REL: dec.op = OP_REL;
            default: dec.op = OP_STAT;
        endcase
    end

    assign o_stall  = (r_cnt == 2'd2);
    assign push     = i_valid && !o_stall;
    assign o_qvalid = (r_cnt != 2'd0);
    assign o_qitem  = r_buf[r_rp];

    // queue pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

    // hold queued items
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= dec;
        end
    end
endmodule

@@ hdl/ltm_back.sv @@
// Back end of the lock table: scans the key store, applies the request to
// the entry and drives the output register. Depends on ltm_pkg, ltm_ram.
`include "assert_macros.svh"
module ltm_back #(
    parameter int ENTRIES    = 64,
    parameter int WAIT_DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_qvalid,
    input  ltm_pkg::t_item i_qitem,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [2:0]    o_status,
    output logic [15:0]   o_client_out,
    output logic [63:0]   o_lock_out,
    output logic [31:0]   o_grant_count,
    output logic          o_last
);
    import ltm_pkg::*;

    localparam int EW  = $clog2(ENTRIES);
    localparam int HW  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int FW  = $clog2(WAIT_DEPTH + 1);
    localparam int SW  = FW + 1;
    localparam int WD  = ENTRIES * WAIT_DEPTH;
    localparam int WAW = $clog2(WD);
    localparam int MW  = 32 + HW + FW;
    localparam logic [EW-1:0] LAST_IDX = EW'(ENTRIES - 1);

    t_state r_state, n_state;
    t_item  r_item;
    logic [EW-1:0] r_idx, r_pidx, r_e;
    logic          r_pv, r_found, r_have_free;
    logic [ENTRIES-1:0] r_valid, r_held;
    logic [15:0]   r_next;
    logic [31:0]   r_g2;
    logic          r_ov;
    logic [2:0]    r_status;
    logic [15:0]   r_client;
    logic [63:0]   r_lock;
    logic [31:0]   r_grants;
    logic          r_last;

    logic [63:0]  key_rdata;
    logic [MW-1:0] meta_rdata, meta_wdata;
    logic [15:0]  wait_rdata;
    logic [WAW-1:0] wait_base, wait_raddr, wait_waddr;

    logic [31:0]   eff_g, g_inc;
    logic [HW-1:0] eff_head, head_nx, pos;
    logic [FW-1:0] eff_fill;
    logic          eff_held;
    logic [SW-1:0] pos_sum, head_sum;
    logic          hit, last_cmp, slot_free, scan_end, out_free, handover;

    logic          push, key_we, meta_we, wait_we, set_valid, held_we, held_val;
    logic [2:0]    res_status;
    logic [15:0]   res_client;
    logic [31:0]   res_grants;
    logic          res_last;

    // entry stores
    ltm_ram #(.W(64), .D(ENTRIES)) u_key (
        .i_clk(i_clk), .i_we(key_we), .i_waddr(r_e), .i_wdata(r_item.key),
        .i_raddr(r_idx), .o_rdata(key_rdata)
    );
    ltm_ram #(.W(MW), .D(ENTRIES)) u_meta (
        .i_clk(i_clk), .i_we(meta_we), .i_waddr(r_e), .i_wdata(meta_wdata),
        .i_raddr(r_e), .o_rdata(meta_rdata)
    );
    ltm_ram #(.W(16), .D(WD)) u_wait (
        .i_clk(i_clk), .i_we(wait_we), .i_waddr(wait_waddr), .i_wdata(r_item.client),
        .i_raddr(wait_raddr), .o_rdata(wait_rdata)
    );

    // entry view; a new entry reads as all zero
    assign eff_held = r_found && r_held[r_e];
    assign eff_g    = r_found ? meta_rdata[MW-1 -: 32] : 32'd0;
    assign eff_head = r_found ? meta_rdata[FW +: HW] : '0;
    assign eff_fill = r_found ? meta_rdata[FW-1:0] : '0;
    assign g_inc    = (eff_g == GRANT_MAX) ? eff_g : eff_g + 32'd1;

    // ring positions in the wait queue
    assign pos_sum  = SW'(eff_head) + SW'(eff_fill);
    assign pos      = HW'((pos_sum >= SW'(WAIT_DEPTH)) ? pos_sum - SW'(WAIT_DEPTH) : pos_sum);
    assign head_sum = SW'(eff_head) + SW'(1);
    assign head_nx  = (head_sum == SW'(WAIT_DEPTH)) ? '0 : HW'(head_sum);
    assign wait_base  = WAW'(WAW'(r_e) * WAW'(WAIT_DEPTH));
    assign wait_raddr = wait_base + WAW'(eff_head);
    assign wait_waddr = wait_base + WAW'(pos);

    // scan compare, one entry per cycle
    assign hit       = r_pv && r_valid[r_pidx] && (key_rdata == r_item.key);
    assign last_cmp  = r_pv && (r_pidx == LAST_IDX);
    assign slot_free = r_pv && !r_valid[r_pidx];
    assign scan_end  = hit || last_cmp;

    assign out_free = !r_ov || !i_stall;
    assign handover = (r_item.op == OP_REL) && eff_held && (eff_fill != '0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_qvalid) n_state = S_SCAN;
            S_SCAN:   if (scan_end) n_state = S_MREAD;
            S_MREAD:  n_state = S_EXEC;
            S_EXEC: begin
                if (handover) n_state = S_WDATA;
                else if (push) n_state = S_IDLE;
            end
            S_WDATA:  if (push) n_state = S_SECOND;
            S_SECOND: if (push) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // results and table writes
    always_comb begin
        o_pop      = 1'b0;
        push       = 1'b0;
        key_we     = 1'b0;
        meta_we    = 1'b0;
        wait_we    = 1'b0;
        set_valid  = 1'b0;
        held_we    = 1'b0;
        held_val   = 1'b0;
        meta_wdata = {eff_g, eff_head, eff_fill};
        res_status = ST_OK;
        res_client = r_item.client;
        res_grants = eff_g;
        res_last   = 1'b1;
        unique case (r_state)
            S_IDLE: o_pop = i_qvalid;
            S_EXEC: begin
                case (r_item.op)
                    OP_ACQ: begin
                        if (!r_found && !r_have_free) begin
                            res_status = ST_FULL;
                            push       = out_free;
                        end else if (!eff_held) begin
                            res_grants = g_inc;
                            push       = out_free;
                            key_we     = push && !r_found;
                            set_valid  = push;
                            held_we    = push;
                            held_val   = 1'b1;
                            meta_we    = push;
                            meta_wdata = {g_inc, eff_head, eff_fill};
                        end else if (eff_fill >= FW'(WAIT_DEPTH)) begin
                            res_status = ST_QFULL;
                            push       = out_free;
                        end else begin
                            res_status = ST_QUEUED;
                            push       = out_free;
                            wait_we    = push;
                            meta_we    = push;
                            meta_wdata = {eff_g, eff_head, eff_fill + FW'(1)};
                        end
                    end
                    OP_REL: begin
                        if (!r_found) begin
                            res_status = ST_NOENT;
                            push       = out_free;
                        end else if (!handover) begin
                            push     = out_free;
                            held_we  = push;
                            held_val = 1'b0;
                        end
                    end
                    default: push = out_free;
                endcase
            end
            S_WDATA: begin
                res_grants = g_inc;
                res_last   = 1'b0;
                push       = out_free;
                meta_we    = push;
                meta_wdata = {g_inc, head_nx, eff_fill - FW'(1)};
            end
            S_SECOND: begin
                res_client = r_next;
                res_grants = r_g2;
                push       = out_free;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pv    <= 1'b0;
            r_valid <= '0;
            r_held  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_pv <= 1'b0;
            end else if (r_state == S_SCAN) begin
                r_pv <= 1'b1;
            end
            if (set_valid) begin
                r_valid[r_e] <= 1'b1;
            end
            if (held_we) begin
                r_held[r_e] <= held_val;
            end
            if (push) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // item, scan and result registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item      <= i_qitem;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_have_free <= 1'b0;
        end
        if (r_state == S_SCAN) begin
            r_pidx <= r_idx;
            if (r_idx != LAST_IDX) begin
                r_idx <= r_idx + EW'(1);
            end
            if (hit) begin
                r_found <= 1'b1;
                r_e     <= r_pidx;
            end else if (slot_free && !r_have_free) begin
                r_have_free <= 1'b1;
                r_e         <= r_pidx;
            end
        end
        if (r_state == S_WDATA) begin
            r_next <= wait_rdata;
            r_g2   <= g_inc;
        end
        if (push) begin
            r_status <= res_status;
            r_client <= res_client;
            r_lock   <= r_item.key;
            r_grants <= res_grants;
            r_last   <= res_last;
        end
    end

    assign o_valid       = r_ov;
    assign o_status      = r_status;
    assign o_client_out  = r_client;
    assign o_lock_out    = r_lock;
    assign o_grant_count = r_grants;
    assign o_last        = r_last;

    `LTM_ASSERT_IMP(a_no_overwrite, r_ov && i_stall, !push)
    `LTM_ASSERT_IMP(a_pop_idle, o_pop, r_state == S_IDLE)
    `LTM_ASSERT_NXT(a_first_then_second, push && (r_state == S_WDATA), r_state == S_SECOND)
    `LTM_ASSERT_IMP(a_fill_bound, (r_state == S_EXEC) && r_found,
                    eff_fill <= FW'(WAIT_DEPTH))
endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for lock_table_manager: random and directed lock requests,
// each result checked against a behavioral copy of the lock table.
// Depends on ltm_pkg and the lock_table_manager RTL.
`timescale 1ns / 100ps

module testbench;
    import ltm_pkg::*;

    localparam int NUM_LOCKS   = 64;
    localparam int QUEUE_DEPTH = 4;
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 800000;
    localparam int LONG_HOLD_AT = 300;
    localparam int LONG_HOLD_LEN = 600;

    typedef struct {
        logic [1:0]  cmd;
        logic [15:0] client;
        logic [63:0] key;
        bit          drain;
    } t_request;

    typedef struct {
        logic [2:0]  status;
        logic [15:0] client;
        logic [63:0] key;
        logic [31:0] grants;
        logic        last;
    } t_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_command = '0;
    logic [15:0] i_client = '0;
    logic [63:0] i_lock_id = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_status;
    logic [15:0] o_client_out;
    logic [63:0] o_lock_out;
    logic [31:0] o_grant_count;
    logic        o_last;

    t_request pending_requests[$];
    t_reply   expected_replies[$];
    int errors = 0;
    int cycles = 0;
    int sent_count = 0;
    int reply_count = 0;

    // Lock table copy
    bit          tbl_valid[NUM_LOCKS];
    logic [63:0] tbl_key[NUM_LOCKS];
    bit          tbl_held[NUM_LOCKS];
    logic [31:0] tbl_grants[NUM_LOCKS];
    logic [15:0] tbl_waiters[NUM_LOCKS][QUEUE_DEPTH];
    int          tbl_head[NUM_LOCKS];
    int          tbl_fill[NUM_LOCKS];

    logic [63:0] key_pool[12];

    lock_table_manager i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_command(i_command), .i_client(i_client), .i_lock_id(i_lock_id),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_status(o_status), .o_client_out(o_client_out), .o_lock_out(o_lock_out),
        .o_grant_count(o_grant_count), .o_last(o_last)
    );

    always #2 i_clk = ~i_clk;

    // Abort on a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    function automatic void add_reply(logic [2:0] st, logic [15:0] cl, logic [63:0] k,
                                      logic [31:0] g, logic lst);
        t_reply r;
        r.status = st; r.client = cl; r.key = k; r.grants = g; r.last = lst;
        expected_replies.push_back(r);
    endfunction

    // Apply one request to the table copy and queue its replies
    function automatic void apply_lock_request(t_request rq);
        int e;
        int pos;
        logic [15:0] next;
        e = -1;
        for (int i = NUM_LOCKS - 1; i >= 0; i--)
            if (tbl_valid[i] && tbl_key[i] == rq.key) e = i;
        if (rq.cmd == CMD_ACQ) begin
            if (e < 0) begin
                for (int i = NUM_LOCKS - 1; i >= 0; i--)
                    if (!tbl_valid[i]) e = i;
                if (e < 0) begin
                    add_reply(ST_FULL, rq.client, rq.key, '0, 1'b1);
                    return;
                end
                tbl_valid[e] = 1; tbl_key[e] = rq.key; tbl_held[e] = 0;
                tbl_grants[e] = '0; tbl_head[e] = 0; tbl_fill[e] = 0;
            end
            if (!tbl_held[e]) begin
                tbl_held[e] = 1;
                if (tbl_grants[e] != GRANT_MAX) tbl_grants[e]++;
                add_reply(ST_OK, rq.client, rq.key, tbl_grants[e], 1'b1);
            end else if (tbl_fill[e] >= QUEUE_DEPTH) begin
                add_reply(ST_QFULL, rq.client, rq.key, tbl_grants[e], 1'b1);
            end else begin
                pos = (tbl_head[e] + tbl_fill[e]) % QUEUE_DEPTH;
                tbl_waiters[e][pos] = rq.client;
                tbl_fill[e]++;
                add_reply(ST_QUEUED, rq.client, rq.key, tbl_grants[e], 1'b1);
            end
        end else if (rq.cmd == CMD_REL) begin
            if (e < 0) begin
                add_reply(ST_NOENT, rq.client, rq.key, '0, 1'b1);
            end else if (tbl_held[e] && tbl_fill[e] > 0) begin
                next = tbl_waiters[e][tbl_head[e]];
                tbl_head[e] = (tbl_head[e] + 1) % QUEUE_DEPTH;
                tbl_fill[e]--;
                if (tbl_grants[e] != GRANT_MAX) tbl_grants[e]++;
                add_reply(ST_OK, rq.client, rq.key, tbl_grants[e], 1'b0);
                add_reply(ST_OK, next, rq.key, tbl_grants[e], 1'b1);
            end else begin
                tbl_held[e] = 0;
                add_reply(ST_OK, rq.client, rq.key, tbl_grants[e], 1'b1);
            end
        end else begin
            add_reply(ST_OK, rq.client, rq.key, (e < 0) ? 32'd0 : tbl_grants[e], 1'b1);
        end
    endfunction

    function automatic int pick_gap(int idx);
        int r;
        r = $urandom_range(0, 99);
        if ((idx % 256) < 64 || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Driver: offer queued requests with random gaps
    int send_gap = 0;
    always @(posedge i_clk) begin
        t_request rq;
        bit busy;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            busy = i_valid;
            if (i_valid && !o_stall) begin
                rq.cmd = i_command; rq.client = i_client; rq.key = i_lock_id;
                apply_lock_request(rq);
                sent_count++;
                busy = 0;
            end
            if (!busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_requests.size() > 0 &&
                             !(pending_requests[0].drain && expected_replies.size() > 0)) begin
                    rq = pending_requests.pop_front();
                    i_command <= rq.cmd;
                    i_client <= rq.client;
                    i_lock_id <= rq.key;
                    i_valid <= 1'b1;
                    send_gap = pick_gap(sent_count);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall, with one long hold-off
    int hold_left = 0;
    bit long_done = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (!long_done && reply_count >= LONG_HOLD_AT) begin
            long_done = 1;
            hold_left = LONG_HOLD_LEN;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            hold_left = pick_gap(reply_count);
            i_stall <= (hold_left > 0);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Monitor: check each reply against the oldest expectation
    always @(posedge i_clk) begin
        t_reply ex;
        if (i_rst_n && o_valid && !i_stall) begin
            reply_count++;
            if (expected_replies.size() == 0) begin
                $display("%0t: unexpected reply status %0d client %h lock %h", $realtime,
                         o_status, o_client_out, o_lock_out);
                errors++;
            end else begin
                ex = expected_replies.pop_front();
                if (o_status !== ex.status) begin
                    $display("%0t: status exp %0d got %0d", $realtime, ex.status, o_status);
                    errors++;
                end
                if (o_client_out !== ex.client) begin
                    $display("%0t: client exp %h got %h", $realtime, ex.client, o_client_out);
                    errors++;
                end
                if (o_lock_out !== ex.key) begin
                    $display("%0t: lock exp %h got %h", $realtime, ex.key, o_lock_out);
                    errors++;
                end
                if (o_grant_count !== ex.grants) begin
                    $display("%0t: grants exp %0d got %0d", $realtime, ex.grants,
                             o_grant_count);
                    errors++;
                end
                if (o_last !== ex.last) begin
                    $display("%0t: last exp %b got %b", $realtime, ex.last, o_last);
                    errors++;
                end
            end
        end
    end

    function automatic void queue_request(logic [1:0] cmd, logic [15:0] cl, logic [63:0] k,
                                          bit drain = 0);
        t_request rq;
        rq.cmd = cmd; rq.client = cl; rq.key = k; rq.drain = drain;
        pending_requests.push_back(rq);
    endfunction

    function automatic logic [63:0] fresh_key();
        return {$urandom(), $urandom()};
    endfunction

    // Random mix over the key pool, with some fresh ids
    function automatic void queue_random(int count);
        logic [1:0] cmd;
        logic [63:0] k;
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 45) cmd = CMD_ACQ;
            else if (r < 80) cmd = CMD_REL;
            else if (r < 95) cmd = CMD_STAT;
            else cmd = CMD_SPARE;
            k = ($urandom_range(0, 99) < 5) ? fresh_key() : key_pool[$urandom_range(0, 11)];
            queue_request(cmd, 16'($urandom()), k);
        end
    endfunction

    initial begin
        logic [63:0] kmax;
        for (int i = 0; i < NUM_LOCKS; i++) begin
            tbl_valid[i] = 0; tbl_held[i] = 0; tbl_grants[i] = '0;
            tbl_head[i] = 0; tbl_fill[i] = 0;
        end
        kmax = '1;
        key_pool[0] = '0;
        key_pool[1] = kmax;
        for (int i = 2; i < 12; i++) key_pool[i] = fresh_key();

        // Directed: queue to full, hand-overs, unknown ids, spare command
        queue_request(CMD_ACQ, 16'h0000, 64'd0);
        queue_request(CMD_ACQ, 16'hFFFF, 64'd0);
        queue_request(CMD_ACQ, 16'h0001, 64'd0);
        queue_request(CMD_ACQ, 16'h0002, 64'd0);
        queue_request(CMD_ACQ, 16'h0003, 64'd0);
        queue_request(CMD_ACQ, 16'h0004, 64'd0);
        queue_request(CMD_STAT, 16'h0000, 64'd0);
        for (int i = 0; i < 5; i++) queue_request(CMD_REL, 16'h1234, 64'd0);
        queue_request(CMD_REL, 16'h0000, 64'd0);
        queue_request(CMD_REL, 16'hFFFF, kmax);
        queue_request(CMD_STAT, 16'hFFFF, kmax);
        queue_request(CMD_SPARE, 16'h0000, kmax);
        queue_request(CMD_ACQ, 16'hFFFF, kmax);
        queue_request(CMD_SPARE, 16'hFFFF, 64'd0, 1);

        // Random over a small set of ids, then fill the table and keep going
        queue_random(350);
        queue_request(CMD_ACQ, 16'($urandom()), key_pool[2], 1);
        queue_random(350);
        for (int i = 0; i < 70; i++) queue_request(CMD_ACQ, 16'($urandom()), fresh_key());
        queue_request(CMD_REL, 16'($urandom()), fresh_key(), 1);
        queue_random(500);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_requests.size() == 0);
        @(posedge i_clk);
        while (i_valid || expected_replies.size() > 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (errors == 0 && expected_replies.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/ltm_pkg.sv
hdl/ltm_ram.sv
hdl/ltm_front.sv
hdl/ltm_back.sv
hdl/lock_table_manager.sv
tb/testbench.sv
